/* design/mtt_pkg.sv */
// Shared types and constants for the table-driven Mealy transducer.
`timescale 1ns / 1ps
`default_nettype none

package mtt_pkg;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_SYMBOL = 2'd1,
    OP_END    = 2'd2,
    OP_NONE   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_FIRST_LETTER = 3'd0,
    REG_LETTER_COUNT = 3'd1,
    REG_STATE_COUNT  = 3'd2,
    REG_START_STATE  = 3'd3,
    REG_FINAL_STATE  = 3'd4
  } cfg_reg_e;

  typedef enum logic {
    BK_EXEC,
    BK_READ
  } back_state_e;

  localparam logic       RES_CHAR    = 1'b0;
  localparam logic       RES_VERDICT = 1'b1;
  localparam logic [7:0] EMPTY_MARK  = 8'h24;

  localparam logic [7:0] FIRST_LETTER_RST = 8'd97;
  localparam logic [5:0] LETTER_COUNT_RST = 6'd26;
  localparam logic [6:0] STATE_COUNT_RST  = 7'd64;
  localparam logic [5:0] START_STATE_RST  = 6'd0;
  localparam logic [5:0] FINAL_STATE_RST  = 6'd0;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] symbol;
    logic [5:0] entry_state;
    logic [4:0] entry_letter;
    logic [5:0] entry_next;
    logic [7:0] entry_char;
  } in_item_t;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] out_char;
    logic       accepted;
    logic       word_fault;
  } out_item_t;

  typedef struct packed {
    logic [7:0] first_letter;
    logic [5:0] letter_count;
    logic [6:0] state_count;
    logic [5:0] start_state;
    logic [5:0] final_state;
  } cfg_t;

  typedef struct packed {
    op_e        kind;
    logic [7:0] letter;
    logic       letter_ok;
    logic       load_ok;
    logic [5:0] entry_state;
    logic [4:0] entry_letter;
    logic [5:0] entry_next;
    logic [7:0] entry_char;
  } cmd_t;

  typedef struct packed {
    logic [5:0] next_state;
    logic [7:0] out_char;
  } entry_t;

endpackage

`default_nettype wire

/* design/mtt_fifo.sv */
// Two-entry queue used between the front, the back and the result port.
`timescale 1ns / 1ps
`default_nettype none

module mtt_fifo #(
  parameter int WIDTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] data_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] data_o,
  output logic                  empty_o
);

  logic [WIDTH-1:0] mem_q [2];
  logic             wr_ptr_q, rd_ptr_q;
  logic [1:0]       cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
      if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 2'd1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

endmodule

`default_nettype wire

/* design/mtt_front.sv */
// Front end: accepts items, classifies them and queues commands for the back end.
`timescale 1ns / 1ps
`default_nettype none

module mtt_front import mtt_pkg::*; #(
  parameter int MAX_STATES,
  parameter int MAX_LETTERS
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_i,
  output logic          full_o,
  input  wire in_item_t item_i,
  input  wire cfg_t     cfg_i,
  output cmd_t          cmd_o,
  output logic          cmd_empty_o,
  input  wire logic     cmd_pop_i
);

  cmd_t                  cmd;
  logic                  cmd_push;
  logic [$bits(cmd_t)-1:0] cmd_bits;

  always_comb begin
    cmd.kind         = op_e'(item_i.operation);
    cmd.letter       = item_i.symbol - cfg_i.first_letter;
    cmd.letter_ok    = (cmd.letter < {2'b00, cfg_i.letter_count}) &&
                       (32'(cmd.letter) < 32'(MAX_LETTERS));
    cmd.load_ok      = (32'(item_i.entry_state) < 32'(MAX_STATES)) &&
                       (32'(item_i.entry_letter) < 32'(MAX_LETTERS));
    cmd.entry_state  = item_i.entry_state;
    cmd.entry_letter = item_i.entry_letter;
    cmd.entry_next   = item_i.entry_next;
    cmd.entry_char   = item_i.entry_char;
  end

  // the unused operation code is dropped here
  assign cmd_push = push_i && (cmd.kind != OP_NONE);
  assign cmd_o    = cmd_t'(cmd_bits);

  mtt_fifo #(
    .WIDTH ($bits(cmd_t))
  ) u_cmd_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd),
    .full_o  (full_o),
    .pop_i   (cmd_pop_i),
    .data_o  (cmd_bits),
    .empty_o (cmd_empty_o)
  );

endmodule

`default_nettype wire

/* design/mtt_back.sv */
// Back end: transition table, word state and result generation.
`timescale 1ns / 1ps
`default_nettype none

module mtt_back import mtt_pkg::*; #(
  parameter int MAX_STATES,
  parameter int MAX_LETTERS
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire cfg_t  cfg_i,
  input  wire cmd_t  cmd_i,
  input  wire logic  cmd_empty_i,
  output logic       cmd_pop_o,
  output logic       res_push_o,
  output out_item_t  res_o,
  input  wire logic  res_full_i
);

  localparam int Depth = MAX_STATES * MAX_LETTERS;
  localparam int AW    = $clog2(Depth);

  entry_t      mem_q [Depth];
  entry_t      rdata_q;
  back_state_e state_q, state_d;
  logic [5:0]  cur_q, cur_d;
  logic        in_word_q, in_word_d;
  logic        fault_q, fault_d;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  logic [5:0]    eff_state;
  logic          eff_fault;
  logic          flt;

  function automatic logic state_ok(logic [5:0] s, logic [6:0] cnt);
    return ({1'b0, s} < cnt) && (32'(s) < 32'(MAX_STATES));
  endfunction

  assign eff_state = in_word_q ? cur_q : cfg_i.start_state;
  assign eff_fault = in_word_q && fault_q;
  assign waddr = AW'(32'(cmd_i.entry_state) * 32'(MAX_LETTERS) + 32'(cmd_i.entry_letter));
  assign raddr = AW'(32'(eff_state) * 32'(MAX_LETTERS) + 32'(cmd_i.letter));

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    in_word_d  = in_word_q;
    fault_d    = fault_q;
    we         = 1'b0;
    re         = 1'b0;
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    flt        = eff_fault;
    res_o      = '{result_kind: RES_CHAR, out_char: rdata_q.out_char,
                   accepted: 1'b0, word_fault: 1'b0};
    unique case (state_q)
      BK_EXEC: begin
        if (!cmd_empty_i && !res_full_i) begin
          cmd_pop_o = 1'b1;
          case (cmd_i.kind)
            OP_LOAD: begin
              we = cmd_i.load_ok;
            end
            OP_SYMBOL: begin
              in_word_d = 1'b1;
              cur_d     = eff_state;
              fault_d   = eff_fault;
              if (!eff_fault) begin
                if (!cmd_i.letter_ok || !state_ok(eff_state, cfg_i.state_count)) begin
                  fault_d = 1'b1;
                end else begin
                  re      = 1'b1;
                  state_d = BK_READ;
                end
              end
            end
            OP_END: begin
              res_push_o = 1'b1;
              res_o      = '{result_kind: RES_VERDICT, out_char: 8'd0,
                             accepted: !flt && (eff_state == cfg_i.final_state),
                             word_fault: flt};
              in_word_d  = 1'b0;
              fault_d    = 1'b0;
              cur_d      = cfg_i.start_state;
            end
            default: ;
          endcase
        end
      end
      BK_READ: begin
        if (!res_full_i) begin
          state_d = BK_EXEC;
          if (!state_ok(rdata_q.next_state, cfg_i.state_count)) begin
            fault_d = 1'b1;
          end else begin
            cur_d      = rdata_q.next_state;
            res_push_o = (rdata_q.out_char != EMPTY_MARK);
          end
        end
      end
      default: state_d = BK_EXEC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_EXEC;
      cur_q     <= 6'd0;
      in_word_q <= 1'b0;
      fault_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_q     <= cur_d;
      in_word_q <= in_word_d;
      fault_q   <= fault_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) mem_q[waddr] <= '{next_state: cmd_i.entry_next, out_char: cmd_i.entry_char};
    if (re) rdata_q <= mem_q[raddr];
  end

endmodule

`default_nettype wire

/* design/mealy_transducer_table.sv */
// Top level of the table-driven Mealy transducer with its configuration registers.
//
// Items enter through push/full and results leave through empty/pop; both sides
// behave as queues. A load item writes one in-range (state, letter) table entry, a
// symbol item steps the automaton and may emit one character, an end-of-word item
// always yields one verdict; operation 3 is dropped.
// A load or end-of-word is done in the back end's execute state; a symbol that
// reads the table also needs its read state, as the synchronous table read's
// next state feeds the next symbol's address. The front end keeps accepting
// into its two-entry queue meanwhile. A verdict reaches the result port through
// the command and result queues, a character also via the table read register.
// When pop stays low, the two-entry result queue fills, the back end holds and
// then the command queue fills and full rises. Nothing is lost.
// Reset empties both queues, clears the word state and sets the registers to their
// defaults. Table contents are undefined until loaded; no clear pass. Registers sit
// at byte addresses 0, 4, 8, 12, 16; the user writes only while idle (unenforced).
`timescale 1ns / 1ps
`default_nettype none

module mealy_transducer_table import mtt_pkg::*; #(
  parameter int MAX_STATES  = 64,
  parameter int MAX_LETTERS = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire in_item_t    item_i,
  output logic             empty,
  input  wire logic        pop,
  output out_item_t        item_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  cfg_t      cfg_q;
  cfg_reg_e  reg_sel;
  logic      cfg_we;
  cmd_t      cmd;
  logic      cmd_empty, cmd_pop;
  logic      res_push, res_full;
  out_item_t res;
  logic [$bits(out_item_t)-1:0] out_bits;

  assign pready  = 1'b1;
  assign reg_sel = cfg_reg_e'(paddr[4:2]);
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{first_letter: FIRST_LETTER_RST, letter_count: LETTER_COUNT_RST,
                 state_count: STATE_COUNT_RST, start_state: START_STATE_RST,
                 final_state: FINAL_STATE_RST};
    end else if (cfg_we) begin
      unique case (reg_sel)
        REG_FIRST_LETTER: cfg_q.first_letter <= pwdata[7:0];
        REG_LETTER_COUNT: cfg_q.letter_count <= pwdata[5:0];
        REG_STATE_COUNT:  cfg_q.state_count  <= pwdata[6:0];
        REG_START_STATE:  cfg_q.start_state  <= pwdata[5:0];
        REG_FINAL_STATE:  cfg_q.final_state  <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_FIRST_LETTER: prdata = {24'd0, cfg_q.first_letter};
      REG_LETTER_COUNT: prdata = {26'd0, cfg_q.letter_count};
      REG_STATE_COUNT:  prdata = {25'd0, cfg_q.state_count};
      REG_START_STATE:  prdata = {26'd0, cfg_q.start_state};
      REG_FINAL_STATE:  prdata = {26'd0, cfg_q.final_state};
      default:          prdata = 32'd0;
    endcase
  end

  mtt_front #(
    .MAX_STATES  (MAX_STATES),
    .MAX_LETTERS (MAX_LETTERS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .item_i      (item_i),
    .cfg_i       (cfg_q),
    .cmd_o       (cmd),
    .cmd_empty_o (cmd_empty),
    .cmd_pop_i   (cmd_pop)
  );

  mtt_back #(
    .MAX_STATES  (MAX_STATES),
    .MAX_LETTERS (MAX_LETTERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .res_push_o  (res_push),
    .res_o       (res),
    .res_full_i  (res_full)
  );

  mtt_fifo #(
    .WIDTH ($bits(out_item_t))
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (out_bits),
    .empty_o (empty)
  );

  assign item_o = out_item_t'(out_bits);

endmodule

`default_nettype wire
